>>> design/assert_macros.svh
// Assertion macros shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/srlt_pkg.sv
// Package with commands, status codes and shared types for the session tracker.
package srlt_pkg;
   localparam int SLOTS_DEFAULT = 64;
   localparam int KEY_W  = 64;
   localparam int MEM_W  = 32;
   localparam int CORE_W = 24;
   localparam int ENTRY_W = 1 + MEM_W + CORE_W + KEY_W;

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_SUB    = 3'd1;
   localparam logic [2:0] CMD_LOCK   = 3'd2;
   localparam logic [2:0] CMD_UNLOCK = 3'd3;
   localparam logic [2:0] CMD_FIND   = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_SESS = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_SAT     = 2'd3;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [KEY_W-1:0]  session_id;
      logic [MEM_W-1:0]  memory_mb;
      logic [CORE_W-1:0] core_amount;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              found;
      logic              is_locked;
      logic [MEM_W-1:0]  session_memory;
      logic [CORE_W-1:0] session_cores;
      logic [MEM_W-1:0]  in_use_memory_total;
      logic [CORE_W-1:0] in_use_core_total;
      logic [MEM_W-1:0]  locked_memory_total;
      logic [CORE_W-1:0] locked_core_total;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture request
      logic scan_start; // reset scan index
      logic scan_step;  // compare current entry, advance
      logic execute;    // apply command using scan result
      logic clear;      // empty table
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_last;
      logic is_clear;
   } ctl_status_type;
endpackage

>>> design/srlt_if.sv
// Valid/ready channel interface carrying one payload.
interface srlt_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/srlt_ram.sv
// Generic single-port RAM with registered read.
module srlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> design/srlt_datapath.sv
// Datapath: session table, scan logic, totals and result formation.
`include "assert_macros.svh"
module srlt_datapath import srlt_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  ctl_cmd_type    ctl,
   output ctl_status_type sts,
   input  req_type        req_in,
   output rsp_type        rsp_out
);
   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   req_type          req_ff;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    cmp_idx_ff;   // index whose data appears on the RAM read port
   logic             cmp_vld_ff;
   logic             hit_ff, free_ok_ff;
   logic [IW-1:0]    hit_idx_ff, free_idx_ff;
   logic             hit_lock_ff;
   logic [MEM_W-1:0] hit_mem_ff;
   logic [CORE_W-1:0] hit_core_ff;
   logic [SLOTS-1:0] valid_ff;
   logic [MEM_W-1:0] tim_ff, tlm_ff;
   logic [CORE_W-1:0] tic_ff, tlc_ff;
   rsp_type          rsp_ff;

   logic               wr_en;
   logic [IW-1:0]      ram_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic               rd_lock;
   logic [MEM_W-1:0]   rd_mem;
   logic [CORE_W-1:0]  rd_core;
   logic [KEY_W-1:0]   rd_key;

   // Execution results.
   logic              e_found, e_lock, e_sat, e_free;
   logic [1:0]        e_status;
   logic [MEM_W-1:0]  e_mem, e_tim, e_tlm;
   logic [CORE_W-1:0] e_core, e_tic, e_tlc;
   logic [MEM_W:0]    s_m0, s_m1, s_m2;
   logic [CORE_W:0]   s_c0, s_c1, s_c2;
   logic [IW-1:0]     e_idx;
   logic              e_write;

   assign {rd_lock, rd_mem, rd_core, rd_key} = rd_data;
   assign sts.scan_last = (idx_ff == LAST);
   assign sts.is_clear  = (req_ff.cmd == CMD_CLEAR);

   always_comb begin
      idx_in = idx_ff;
      if (ctl.scan_start) begin
         idx_in = '0;
      end else if (ctl.scan_step && idx_ff != LAST) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      e_found = hit_ff; e_lock = hit_lock_ff; e_mem = hit_mem_ff; e_core = hit_core_ff;
      e_tim = tim_ff; e_tic = tic_ff; e_tlm = tlm_ff; e_tlc = tlc_ff;
      e_sat = 1'b0; e_free = 1'b0; e_status = ST_OK; e_idx = hit_idx_ff; e_write = 1'b0;
      s_m0 = '0; s_m1 = '0; s_m2 = '0; s_c0 = '0; s_c1 = '0; s_c2 = '0;
      case (req_ff.cmd)
         CMD_ADD: begin
            if (!hit_ff) begin
               e_status = ST_NO_SESS;
            end else begin
               s_m0 = {1'b0, hit_mem_ff} + {1'b0, req_ff.memory_mb};
               s_c0 = {1'b0, hit_core_ff} + {1'b0, req_ff.core_amount};
               s_m1 = {1'b0, tim_ff} + {1'b0, req_ff.memory_mb};
               s_c1 = {1'b0, tic_ff} + {1'b0, req_ff.core_amount};
               e_mem  = s_m0[MEM_W]  ? '1 : s_m0[MEM_W-1:0];
               e_core = s_c0[CORE_W] ? '1 : s_c0[CORE_W-1:0];
               e_tim  = s_m1[MEM_W]  ? '1 : s_m1[MEM_W-1:0];
               e_tic  = s_c1[CORE_W] ? '1 : s_c1[CORE_W-1:0];
               e_sat = s_m0[MEM_W] | s_c0[CORE_W] | s_m1[MEM_W] | s_c1[CORE_W];
               e_write = 1'b1;
            end
         end
         CMD_SUB: begin
            if (!hit_ff) begin
               e_status = ST_NO_SESS;
            end else begin
               s_m0 = {1'b0, hit_mem_ff} - {1'b0, req_ff.memory_mb};
               s_c0 = {1'b0, hit_core_ff} - {1'b0, req_ff.core_amount};
               s_m1 = {1'b0, tim_ff} - {1'b0, req_ff.memory_mb};
               s_c1 = {1'b0, tic_ff} - {1'b0, req_ff.core_amount};
               e_mem  = s_m0[MEM_W]  ? '0 : s_m0[MEM_W-1:0];
               e_core = s_c0[CORE_W] ? '0 : s_c0[CORE_W-1:0];
               e_tim  = s_m1[MEM_W]  ? '0 : s_m1[MEM_W-1:0];
               e_tic  = s_c1[CORE_W] ? '0 : s_c1[CORE_W-1:0];
               e_sat = s_m0[MEM_W] | s_c0[CORE_W] | s_m1[MEM_W] | s_c1[CORE_W];
               e_write = 1'b1;
               if (e_mem == '0 && e_core == '0) begin
                  e_free = 1'b1;
                  e_found = 1'b0;
               end
            end
         end
         CMD_LOCK: begin
            if (!hit_ff && !free_ok_ff) begin
               e_status = ST_FULL;
            end else begin
               if (!hit_ff) begin
                  e_idx = free_idx_ff; e_found = 1'b1;
                  e_lock = 1'b0; e_mem = '0; e_core = '0;
               end
               if (!e_lock) begin
                  s_m2 = {1'b0, tlm_ff} + {1'b0, e_mem};
                  s_c2 = {1'b0, tlc_ff} + {1'b0, e_core};
                  e_tlm = s_m2[MEM_W]  ? '1 : s_m2[MEM_W-1:0];
                  e_tlc = s_c2[CORE_W] ? '1 : s_c2[CORE_W-1:0];
                  e_sat = s_m2[MEM_W] | s_c2[CORE_W];
                  e_lock = 1'b1;
                  e_write = 1'b1;
               end
            end
         end
         CMD_UNLOCK: begin
            if (!hit_ff) begin
               e_status = ST_NO_SESS;
            end else if (hit_lock_ff) begin
               s_m2 = {1'b0, tlm_ff} - {1'b0, hit_mem_ff};
               s_c2 = {1'b0, tlc_ff} - {1'b0, hit_core_ff};
               e_tlm = s_m2[MEM_W]  ? '0 : s_m2[MEM_W-1:0];
               e_tlc = s_c2[CORE_W] ? '0 : s_c2[CORE_W-1:0];
               e_sat = s_m2[MEM_W] | s_c2[CORE_W];
               e_lock = 1'b0;
               e_write = 1'b1;
            end
         end
         CMD_FIND: begin
            if (!hit_ff) begin
               e_status = ST_NO_SESS;
            end
         end
         CMD_CLEAR: begin
            e_found = 1'b0;
            e_tim = '0; e_tic = '0; e_tlm = '0; e_tlc = '0;
         end
         default: ;
      endcase
      if (e_sat) begin
         e_status = ST_SAT;
      end
   end

   assign wr_en    = ctl.execute && e_write && !e_free;
   assign ram_addr = ctl.execute ? e_idx : idx_ff;
   assign wr_data  = {e_lock, e_mem, e_core, req_ff.session_id};

   srlt_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (ram_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_in;
      end
      if (ctl.execute) begin
         rsp_ff.status <= e_status;
         rsp_ff.found  <= e_found;
         rsp_ff.is_locked      <= e_found ? e_lock : 1'b0;
         rsp_ff.session_memory <= e_found ? e_mem  : '0;
         rsp_ff.session_cores  <= e_found ? e_core : '0;
         rsp_ff.in_use_memory_total <= e_tim;
         rsp_ff.in_use_core_total   <= e_tic;
         rsp_ff.locked_memory_total <= e_tlm;
         rsp_ff.locked_core_total   <= e_tlc;
      end
      cmp_idx_ff <= idx_ff;
      // Read data arrives in the cycle after the address; compare it against the captured key.
      if (cmp_vld_ff) begin
         if (!hit_ff && valid_ff[cmp_idx_ff] && rd_key == req_ff.session_id) begin
            hit_idx_ff  <= cmp_idx_ff;
            hit_lock_ff <= rd_lock;
            hit_mem_ff  <= rd_mem;
            hit_core_ff <= rd_core;
         end
         if (!free_ok_ff && !valid_ff[cmp_idx_ff]) begin
            free_idx_ff <= cmp_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0; cmp_vld_ff <= 1'b0; hit_ff <= 1'b0; free_ok_ff <= 1'b0;
         valid_ff <= '0;
         tim_ff <= '0; tic_ff <= '0; tlm_ff <= '0; tlc_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         cmp_vld_ff <= ctl.scan_step;
         if (ctl.scan_start) begin
            hit_ff <= 1'b0;
            free_ok_ff <= 1'b0;
         end else if (cmp_vld_ff) begin
            if (valid_ff[cmp_idx_ff] && rd_key == req_ff.session_id) begin
               hit_ff <= 1'b1;
            end
            if (!valid_ff[cmp_idx_ff]) begin
               free_ok_ff <= 1'b1;
            end
         end
         if (ctl.clear) begin
            valid_ff <= '0;
            tim_ff <= '0; tic_ff <= '0; tlm_ff <= '0; tlc_ff <= '0;
         end else if (ctl.execute) begin
            tim_ff <= e_tim; tic_ff <= e_tic; tlm_ff <= e_tlm; tlc_ff <= e_tlc;
            if (e_free) begin
               valid_ff[e_idx] <= 1'b0;
            end else if (e_write) begin
               valid_ff[e_idx] <= 1'b1;
            end
         end
      end
   end

   assign rsp_out = rsp_ff;

   `ASSERT_IMPLY(a_lock_found, clock, reset,
      ctl.execute && req_ff.cmd == CMD_LOCK && e_status != ST_FULL, e_found,
      "lock did not leave a session")
   `ASSERT_NEXT(a_clear_totals, clock, reset, ctl.clear,
      valid_ff == '0 && tim_ff == '0 && tlm_ff == '0, "clear left state behind")
   `ASSERT_IMPLY(a_total_sat, clock, reset, ctl.execute && e_sat, e_status == ST_SAT,
      "saturation not reported")
endmodule

>>> design/srlt_ctrl.sv
// Controller state machine sequencing capture, table scan, update and response.
`include "assert_macros.svh"
module srlt_ctrl import srlt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output ctl_cmd_type    ctl,
   input  ctl_status_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ctl.load = 1'b1;
               ctl.scan_start = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ctl.execute = 1'b1;
            ctl.clear = sts.is_clear;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_exec_resp, clock, reset, state_ff == S_EXEC, rsp_valid,
      "execute not followed by response")
   `ASSERT_NEXT(a_accept_scan, clock, reset, req_fire, state_ff == S_SCAN,
      "accepted transaction did not start a scan")
endmodule

>>> design/session_resource_lock_tracker_unit.sv
// Top level of the session resource lock tracker.
// For each transaction the controller scans the session table one entry per cycle
// through the single RAM port, waits in S_WAIT for the last read, then in S_EXEC
// applies the command to the matching entry (or a free one for a new lock) and the
// totals; the response is registered and held valid in S_RESP. The next transaction
// can be accepted in the cycle after the response is taken, once the controller is
// back in S_IDLE. One transaction is handled at a time.
module session_resource_lock_tracker_unit import srlt_pkg::*; #(
   parameter int SESSION_SLOTS = SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   srlt_if.sink   req,
   srlt_if.source rsp
);
   ctl_cmd_type    ctl;
   ctl_status_type sts;

   srlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   srlt_datapath #(.SLOTS(SESSION_SLOTS)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .sts     (sts),
      .req_in  (req.payload),
      .rsp_out (rsp.payload)
   );
endmodule
